// ===== rtl/rarmr_pkg.sv =====
// ----------------------------------------------------------------------------
// rarmr_pkg
// Shared widths, controller states and the control/status structs of the
// rational add/multiply/reduce block.
// ----------------------------------------------------------------------------
package rarmr_pkg;

    localparam int OPERAND_WIDTH   = 16;
    localparam int PROD_WIDTH      = 2 * OPERAND_WIDTH;
    localparam int MAG_WIDTH       = PROD_WIDTH + 1;
    localparam int NUM_FIELD_WIDTH = 33;
    localparam int DEN_FIELD_WIDTH = 32;
    localparam int DIV_CNT_WIDTH   = $clog2(MAG_WIDTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_GINIT,
        ST_GTEST,
        ST_GWAIT,
        ST_QNWAIT,
        ST_QDWAIT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_EUCLID,
        DIV_NUM,
        DIV_DEN
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul;
        logic     sum;
        logic     gcd_init;
        logic     euclid_step;
        logic     div_start;
        div_sel_t div_sel;
        logic     store_qn;
        logic     store_qd;
    } cmd_t;

    typedef struct packed {
        logic y_zero;
        logic div_done;
    } status_t;

endpackage

// ===== rtl/rational_add_multiply_reduce_top.sv =====
// ----------------------------------------------------------------------------
// rational_add_multiply_reduce_top
// Adds or multiplies two signed fractions and reduces the result by the
// truncating-remainder Euclid divisor.
//
// Channel   Signals                                   Transfer
// input     start, operation, a_num..b_den            start && !busy
// result    done, res_num, res_den                    done (one cycle)
//
// One item at a time. After the setup states MUL, SUM and GINIT, each Euclid
// remainder step and each of the two reducing divisions runs on one shared
// bit-serial divider of MAG_WIDTH (33) bits; the result strobe follows the
// second reducing division.
// Reset clears the sequencer and the divider control; the result ports
// carry data only while done is high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module rational_add_multiply_reduce_top (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    output logic                                        busy,
    input  logic                                        operation,
    input  logic signed [rarmr_pkg::OPERAND_WIDTH-1:0]  a_num,
    input  logic signed [rarmr_pkg::OPERAND_WIDTH-1:0]  a_den,
    input  logic signed [rarmr_pkg::OPERAND_WIDTH-1:0]  b_num,
    input  logic signed [rarmr_pkg::OPERAND_WIDTH-1:0]  b_den,
    output logic                                        done,
    output logic signed [rarmr_pkg::NUM_FIELD_WIDTH-1:0] res_num,
    output logic signed [rarmr_pkg::DEN_FIELD_WIDTH-1:0] res_den
);

    rarmr_pkg::cmd_t    cmd;
    rarmr_pkg::status_t status;

    logic [rarmr_pkg::NUM_FIELD_WIDTH-1:0] num_q;
    logic [rarmr_pkg::DEN_FIELD_WIDTH-1:0] den_q;

    rarmr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rarmr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .operation (operation),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .res_num   (num_q),
        .res_den   (den_q)
    );

    assign res_num = num_q;
    assign res_den = den_q;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("transfer accepted but block not busy");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside an item");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res_den != '0))
        else $error("reduced denominator is zero");

endmodule

// ===== rtl/rarmr_div.sv =====
// ----------------------------------------------------------------------------
// rarmr_div
// Restoring unsigned divider, one quotient bit per cycle. Gives quotient and
// remainder together; done pulses for one cycle when both are ready.
// ----------------------------------------------------------------------------
module rarmr_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rarmr_pkg::MAG_WIDTH-1:0]   dividend,
    input  logic [rarmr_pkg::MAG_WIDTH-1:0]   divisor,
    output logic                              done,
    output logic [rarmr_pkg::MAG_WIDTH-1:0]   quotient,
    output logic [rarmr_pkg::MAG_WIDTH-1:0]   remainder
);

    localparam int MW = rarmr_pkg::MAG_WIDTH;
    localparam int CW = rarmr_pkg::DIV_CNT_WIDTH;
    localparam logic [CW-1:0] LAST = CW'(MW - 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [MW-1:0] rem_reg, rem_next;
    logic [MW-1:0] quo_reg, quo_next;
    logic [MW-1:0] dvs_reg, dvs_next;

    logic [MW:0]   shifted;
    logic [MW:0]   diff;
    logic          ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[MW-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = !diff[MW];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so MW bits hold it
            rem_next = ge ? diff[MW-1:0] : shifted[MW-1:0];
            quo_next = {quo_reg[MW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/rarmr_datapath.sv =====
// ----------------------------------------------------------------------------
// rarmr_datapath
// Operand capture, products, signed sum, Euclid registers and final reduction
// in sign/magnitude; results in two's complement. Sequenced by rarmr_ctrl.
// ----------------------------------------------------------------------------
module rarmr_datapath (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  rarmr_pkg::cmd_t                             cmd,
    output rarmr_pkg::status_t                          status,
    input  logic                                        operation,
    input  logic        [rarmr_pkg::OPERAND_WIDTH-1:0]  a_num,
    input  logic        [rarmr_pkg::OPERAND_WIDTH-1:0]  a_den,
    input  logic        [rarmr_pkg::OPERAND_WIDTH-1:0]  b_num,
    input  logic        [rarmr_pkg::OPERAND_WIDTH-1:0]  b_den,
    output logic [rarmr_pkg::NUM_FIELD_WIDTH-1:0]       res_num,
    output logic [rarmr_pkg::DEN_FIELD_WIDTH-1:0]       res_den
);

    localparam int OW    = rarmr_pkg::OPERAND_WIDTH;
    localparam int PW    = rarmr_pkg::PROD_WIDTH;
    localparam int MW    = rarmr_pkg::MAG_WIDTH;
    localparam int NFW   = rarmr_pkg::NUM_FIELD_WIDTH;
    localparam int DFW   = rarmr_pkg::DEN_FIELD_WIDTH;
    localparam int EXT_N = (MW > NFW) ? MW : NFW;
    localparam int EXT_D = (MW > DFW) ? MW : DFW;

    // captured operands
    logic          op_reg;
    logic          an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;
    logic [OW-1:0] an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;

    // products
    logic          p0_neg_reg, p1_neg_reg, pd_neg_reg;
    logic [PW-1:0] p0_mag_reg, p1_mag_reg, pd_mag_reg;

    // raw fraction
    logic          num_neg_reg, num_neg_next;
    logic [MW-1:0] num_mag_reg, num_mag_next;

    // Euclid chain
    logic [MW-1:0] x_reg, y_reg;
    logic          odd_reg;

    logic [NFW-1:0] res_num_reg;
    logic [DFW-1:0] res_den_reg;

    logic [OW-1:0] an_mag, ad_mag, bn_mag, bd_mag, ad_raw, bd_raw;
    logic [OW-1:0] mul_b;
    logic          mul_b_neg;
    logic [PW-1:0] p0_mag, p1_mag, pd_mag;
    logic [MW-1:0] sx, sy;

    logic          div_done;
    logic [MW-1:0] div_quo, div_rem, div_a, div_b;
    logic          g_neg, qn_neg, qd_neg;
    logic [EXT_N-1:0] qn_ext, qn_field;
    logic [EXT_D-1:0] qd_ext, qd_field;

    always_comb
    begin
        an_mag = a_num[OW-1] ? (~a_num + 1'b1) : a_num;
        bn_mag = b_num[OW-1] ? (~b_num + 1'b1) : b_num;
        ad_raw = a_den[OW-1] ? (~a_den + 1'b1) : a_den;
        bd_raw = b_den[OW-1] ? (~b_den + 1'b1) : b_den;
        // zero denominator counts as one
        ad_mag = (ad_raw == '0) ? OW'(1) : ad_raw;
        bd_mag = (bd_raw == '0) ? OW'(1) : bd_raw;

        mul_b     = op_reg ? bd_mag_reg : bn_mag_reg;
        mul_b_neg = op_reg ? bd_neg_reg : bn_neg_reg;
        p0_mag    = PW'(an_mag_reg) * PW'(mul_b);
        p1_mag    = PW'(bn_mag_reg) * PW'(ad_mag_reg);
        pd_mag    = PW'(ad_mag_reg) * PW'(bd_mag_reg);

        sx = MW'(p0_mag_reg);
        sy = MW'(p1_mag_reg);
        if (!op_reg)
        begin
            num_mag_next = sx;
            num_neg_next = p0_neg_reg;
        end
        else if (p0_neg_reg == p1_neg_reg)
        begin
            num_mag_next = sx + sy;
            num_neg_next = p0_neg_reg;
        end
        else if (sx >= sy)
        begin
            num_mag_next = sx - sy;
            num_neg_next = p0_neg_reg;
        end
        else
        begin
            num_mag_next = sy - sx;
            num_neg_next = p1_neg_reg;
        end
        if (num_mag_next == '0)
        begin
            num_neg_next = 1'b0;
        end
    end

    always_comb
    begin
        case (cmd.div_sel)
            rarmr_pkg::DIV_EUCLID:
            begin
                div_a = x_reg;
                div_b = y_reg;
            end
            rarmr_pkg::DIV_NUM:
            begin
                div_a = num_mag_reg;
                div_b = x_reg;
            end
            rarmr_pkg::DIV_DEN:
            begin
                div_a = MW'(pd_mag_reg);
                div_b = x_reg;
            end
            default:
            begin
                div_a = x_reg;
                div_b = y_reg;
            end
        endcase
    end

    rarmr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // divisor sign alternates num, den, num, ... along the remainder chain
    always_comb
    begin
        g_neg    = odd_reg ? pd_neg_reg : num_neg_reg;
        qn_neg   = (div_quo != '0) && (num_neg_reg != g_neg);
        qd_neg   = pd_neg_reg != g_neg;
        qn_ext   = EXT_N'(div_quo);
        qd_ext   = EXT_D'(div_quo);
        qn_field = qn_neg ? (~qn_ext + 1'b1) : qn_ext;
        qd_field = qd_neg ? (~qd_ext + 1'b1) : qd_ext;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            an_neg_reg <= a_num[OW-1];
            bn_neg_reg <= b_num[OW-1];
            ad_neg_reg <= a_den[OW-1] && (ad_raw != '0);
            bd_neg_reg <= b_den[OW-1] && (bd_raw != '0);
            an_mag_reg <= an_mag;
            bn_mag_reg <= bn_mag;
            ad_mag_reg <= ad_mag;
            bd_mag_reg <= bd_mag;
        end
        if (cmd.mul)
        begin
            p0_mag_reg <= p0_mag;
            p1_mag_reg <= p1_mag;
            pd_mag_reg <= pd_mag;
            p0_neg_reg <= (p0_mag != '0) && (an_neg_reg != mul_b_neg);
            p1_neg_reg <= (p1_mag != '0) && (bn_neg_reg != ad_neg_reg);
            pd_neg_reg <= ad_neg_reg != bd_neg_reg;
        end
        if (cmd.sum)
        begin
            num_mag_reg <= num_mag_next;
            num_neg_reg <= num_neg_next;
        end
        if (cmd.gcd_init)
        begin
            x_reg   <= num_mag_reg;
            y_reg   <= MW'(pd_mag_reg);
            odd_reg <= 1'b0;
        end
        else if (cmd.euclid_step)
        begin
            x_reg   <= y_reg;
            y_reg   <= div_rem;
            odd_reg <= !odd_reg;
        end
        if (cmd.store_qn)
        begin
            res_num_reg <= qn_field[NFW-1:0];
        end
        if (cmd.store_qd)
        begin
            res_den_reg <= qd_field[DFW-1:0];
        end
    end

    assign status.y_zero   = (y_reg == '0);
    assign status.div_done = div_done;
    assign res_num         = res_num_reg;
    assign res_den         = res_den_reg;

endmodule

// ===== rtl/rarmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// rarmr_ctrl
// Sequencer: products, sum, Euclid remainder loop on the shared divider,
// then the two reducing divisions and the result strobe.
// ----------------------------------------------------------------------------
module rarmr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rarmr_pkg::status_t  status,
    output rarmr_pkg::cmd_t     cmd,
    output logic                busy,
    output logic                done
);

    rarmr_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rarmr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rarmr_pkg::ST_MUL;
                end
            end
            rarmr_pkg::ST_MUL:   state_next = rarmr_pkg::ST_SUM;
            rarmr_pkg::ST_SUM:   state_next = rarmr_pkg::ST_GINIT;
            rarmr_pkg::ST_GINIT: state_next = rarmr_pkg::ST_GTEST;
            rarmr_pkg::ST_GTEST:
            begin
                state_next = status.y_zero ? rarmr_pkg::ST_QNWAIT : rarmr_pkg::ST_GWAIT;
            end
            rarmr_pkg::ST_GWAIT:
            begin
                if (status.div_done)
                begin
                    state_next = rarmr_pkg::ST_GTEST;
                end
            end
            rarmr_pkg::ST_QNWAIT:
            begin
                if (status.div_done)
                begin
                    state_next = rarmr_pkg::ST_QDWAIT;
                end
            end
            rarmr_pkg::ST_QDWAIT:
            begin
                if (status.div_done)
                begin
                    state_next = rarmr_pkg::ST_OUT;
                end
            end
            rarmr_pkg::ST_OUT:   state_next = rarmr_pkg::ST_IDLE;
            default:             state_next = rarmr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = rarmr_pkg::DIV_EUCLID;
        case (state_reg)
            rarmr_pkg::ST_IDLE:  cmd.load     = start;
            rarmr_pkg::ST_MUL:   cmd.mul      = 1'b1;
            rarmr_pkg::ST_SUM:   cmd.sum      = 1'b1;
            rarmr_pkg::ST_GINIT: cmd.gcd_init = 1'b1;
            rarmr_pkg::ST_GTEST:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = status.y_zero ? rarmr_pkg::DIV_NUM : rarmr_pkg::DIV_EUCLID;
            end
            rarmr_pkg::ST_GWAIT: cmd.euclid_step = status.div_done;
            rarmr_pkg::ST_QNWAIT:
            begin
                // quotient of the numerator lands; kick off the denominator
                cmd.store_qn  = status.div_done;
                cmd.div_start = status.div_done;
                cmd.div_sel   = rarmr_pkg::DIV_DEN;
            end
            rarmr_pkg::ST_QDWAIT: cmd.store_qd = status.div_done;
            rarmr_pkg::ST_OUT:    cmd         = '0;
            default:              cmd         = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rarmr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != rarmr_pkg::ST_IDLE);
    assign done = (state_reg == rarmr_pkg::ST_OUT);

endmodule
